>>> sv/bfp_pkg.sv
package bfp_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam logic [3:0] CORNER_WEIGHT = 4'd4;
  localparam logic [3:0] EDGE_WEIGHT   = 4'd2;
  localparam logic [3:0] CENTER_WEIGHT = 4'd1;

  localparam int SUM_W   = 16;
  localparam int COORD_W = 11;
  localparam int CFG_W   = 12;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_BLUR_DIVISOR,
    REG_RED_FADE,
    REG_GREEN_FADE,
    REG_BLUE_FADE
  } reg_index_t;

  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd1920;
  localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd1080;
  localparam logic [7:0]  RST_BLUR_DIVISOR = 8'd25;
  localparam logic [7:0]  RST_RED_FADE     = 8'h1;
  localparam logic [7:0]  RST_GREEN_FADE   = 8'h3;
  localparam logic [7:0]  RST_BLUE_FADE    = 8'h1;

  typedef struct packed {
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } pixel_in_t;

  typedef struct packed {
    logic [10:0] out_column;
    logic [10:0] out_row;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic        frame_end;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [7:0]  blur_divisor;
    logic [7:0]  red_fade;
    logic [7:0]  green_fade;
    logic [7:0]  blue_fade;
  } cfg_t;

  typedef logic [23:0] pix_t;
  typedef logic [8:0][23:0] win_t;

  typedef struct packed {
    win_t               win;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               col_one;
    logic               row_one;
    logic [3:0]         mask;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_WRITE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUM,
    B_DIV,
    B_OUT
  } back_state_t;

  function automatic logic [3:0] tap_weight(input int i, input int j);
    if (i != 1 && j != 1) return CORNER_WEIGHT;
    if (i != 1 || j != 1) return EDGE_WEIGHT;
    return CENTER_WEIGHT;
  endfunction

endpackage

>>> sv/bfp_front.sv
module bfp_front import bfp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      push,
  input  pixel_in_t pixel,
  output logic      full,
  input  logic      q_full,
  output logic      q_push,
  output job_t      q_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = RW + 1;

  front_state_t state, state_next;
  logic [CW-1:0] col, c_cur, c_eff;
  logic [RW-1:0] row, r_cur, r_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          accept;
  pix_t          pix_hold;
  logic [47:0]   rd;
  logic [47:0]   mem [MAX_WIDTH];
  win_t          win, win_next;
  logic          last_col, last_row, col_nz, row_nz;

  always_comb begin
    if (cfg.image_width < CFG_W'(2)) w_eff = WW'(2);
    else if (32'(cfg.image_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg.image_width);
    if (cfg.image_height < CFG_W'(2)) h_eff = HW'(2);
    else if (32'(cfg.image_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg.image_height);
  end

  assign c_eff  = ({1'b0, col} >= w_eff) ? '0 : col;
  assign r_eff  = ({1'b0, row} >= h_eff) ? '0 : row;
  assign accept = push && !full;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (accept) state_next = F_WRITE;
      F_WRITE: state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  assign last_col = ({1'b0, c_cur} == w_eff - WW'(1));
  assign last_row = ({1'b0, r_cur} == h_eff - HW'(1));
  assign col_nz   = (c_cur != '0);
  assign row_nz   = (r_cur != '0);

  always_comb begin
    full   = (state != F_IDLE) || q_full;
    q_push = 1'b0;
    unique case (state)
      F_IDLE:  q_push = 1'b0;
      F_WRITE: q_push = (q_data.mask != 4'b0);
      default: q_push = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i*3]     = win[i*3+1];
      win_next[i*3 + 1] = win[i*3+2];
    end
    win_next[2] = rd[47:24];
    win_next[5] = rd[23:0];
    win_next[8] = pix_hold;
  end

  always_comb begin
    q_data.win     = win_next;
    q_data.col     = COORD_W'(c_cur);
    q_data.row     = COORD_W'(r_cur);
    q_data.col_one = (c_cur == CW'(1));
    q_data.row_one = (r_cur == RW'(1));
    q_data.mask    = {last_row && last_col, last_row && col_nz,
                      row_nz && last_col, row_nz && col_nz};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if ({1'b0, c_eff} + WW'(1) >= w_eff) begin
          col <= '0;
          row <= ({1'b0, r_eff} + HW'(1) >= h_eff) ? '0 : r_eff + RW'(1);
        end else begin
          col <= c_eff + CW'(1);
          row <= r_eff;
        end
      end
    end
  end

  // line stores: older row in the upper half, newer row in the lower half
  always_ff @(posedge clk) begin
    if (accept) begin
      rd       <= mem[c_eff];
      c_cur    <= c_eff;
      r_cur    <= r_eff;
      pix_hold <= {pixel.in_red, pixel.in_green, pixel.in_blue};
    end
    if (state == F_WRITE) begin
      mem[c_cur] <= {rd[23:0], pix_hold};
      win        <= win_next;
    end
  end

endmodule

>>> sv/bfp_queue.sv
module bfp_queue import bfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t data,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t              store [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign head    = store[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (32'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= (32'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= data;
  end

endmodule

>>> sv/bfp_back.sv
module bfp_back import bfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  job_t    head,
  input  logic    q_empty,
  output logic    q_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  back_state_t state, state_next;
  logic [3:0]  rem, rem_next;
  logic [1:0]  k;
  logic [2:0]  step;
  logic        ox0, oy0;
  logic [1:0]  cr, cc;
  logic [1:0]  rsel [3];
  logic [1:0]  csel [3];
  logic [2:0][SUM_W-1:0] sum;
  logic [2:0][7:0] p, lo, fade, val;
  logic [2:0]  sat;
  logic [7:0]  div;
  logic [10:0] ox, oy;
  logic        fe, last;
  logic        out_valid, out_free, load;
  logic [2:0][8:0] t;
  logic [2:0]  ge;
  logic [7:0]  q;

  assign div      = (cfg.blur_divisor == 8'd0) ? 8'd1 : cfg.blur_divisor;
  assign fade[0]  = cfg.blue_fade;
  assign fade[1]  = cfg.green_fade;
  assign fade[2]  = cfg.red_fade;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_comb begin
    if (rem[0]) k = 2'd0;
    else if (rem[1]) k = 2'd1;
    else if (rem[2]) k = 2'd2;
    else k = 2'd3;
    rem_next = rem & ~(4'b1 << k);
    cr  = k[1] ? 2'd2 : 2'd1;
    cc  = k[0] ? 2'd2 : 2'd1;
    ox0 = !k[0] && head.col_one;
    oy0 = !k[1] && head.row_one;
    rsel[0] = oy0 ? cr : cr - 2'd1;
    rsel[1] = cr;
    rsel[2] = 2'd2;
    csel[0] = ox0 ? cc : cc - 2'd1;
    csel[1] = cc;
    csel[2] = 2'd2;
    sum = '0;
    for (int ch = 0; ch < 3; ch++)
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          sum[ch] = sum[ch] + SUM_W'(head.win[rsel[i]*3 + csel[j]][ch*8 +: 8])
                    * SUM_W'(tap_weight(i, j));
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      t[ch]  = {p[ch], lo[ch][7]};
      ge[ch] = (t[ch] >= {1'b0, div});
    end
  end

  always_comb begin
    q = 8'd0;
    for (int ch = 0; ch < 3; ch++) begin
      q       = sat[ch] ? 8'd255 : lo[ch];
      val[ch] = (q > fade[ch]) ? q - fade[ch] : 8'd0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!q_empty) state_next = B_SUM;
      B_SUM:   state_next = B_DIV;
      B_DIV:   if (step == 3'd7) state_next = B_OUT;
      B_OUT:   if (out_free) state_next = (rem == 4'b0) ? B_IDLE : B_SUM;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    load  = 1'b0;
    q_pop = 1'b0;
    unique case (state)
      B_IDLE, B_SUM, B_DIV: load = 1'b0;
      B_OUT: begin
        load  = out_free;
        q_pop = out_free && (rem == 4'b0);
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty) rem <= head.mask;
    if (state == B_SUM) begin
      rem  <= rem_next;
      ox   <= k[0] ? head.col : head.col - 11'd1;
      oy   <= k[1] ? head.row : head.row - 11'd1;
      fe   <= (k == 2'd3);
      last <= (rem_next == 4'b0);
      step <= 3'd0;
      for (int ch = 0; ch < 3; ch++) begin
        p[ch]   <= sum[ch][15:8];
        lo[ch]  <= sum[ch][7:0];
        sat[ch] <= (sum[ch][15:8] >= div);
      end
    end
    // restoring division, one quotient bit per cycle
    if (state == B_DIV) begin
      step <= step + 3'd1;
      for (int ch = 0; ch < 3; ch++) begin
        p[ch]  <= ge[ch] ? 8'(t[ch] - {1'b0, div}) : t[ch][7:0];
        lo[ch] <= {lo[ch][6:0], ge[ch]};
      end
    end
    if (load) begin
      result.out_column <= ox;
      result.out_row    <= oy;
      result.out_blue   <= val[0];
      result.out_green  <= val[1];
      result.out_red    <= val[2];
      result.frame_end  <= fe;
      result.run_last   <= last;
    end
  end

endmodule

>>> sv/blur3x3_fade_pixel_stream.sv
// 3x3 weighted blur with edge replication and per-channel fade.
// input: pixels in raster order, a beat taken when push is high and full low.
// output: filtered pixels tagged with column and row, a beat taken when pop is
// high and empty low; run_last marks the final result of an input pixel and
// frame_end the bottom-right pixel of the frame.
// config: cfg_we writes cfg_data into register cfg_index; write
// only while idle.
// an input pixel gives 0 to 4 results. the front takes a pixel as a line
// store read, then a window and store update, and takes no new pixel until
// that update is done or while the job queue is full. in the back each result
// passes B_SUM for the weighted sums, B_DIV for the restoring dividers (one per
// channel) and B_OUT, which loads the output register once it is free.
// a stalled output holds its result; the back then waits and the two-entry job
// queue fills before full is raised to the sender.
// reset restores the register defaults and restarts at column 0, row 0;
// the line stores need no clearing.
module blur3x3_fade_pixel_stream import bfp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pixel_in_t        pixel,
  output logic             full,
  input  logic             pop,
  output result_t          result,
  output logic             empty,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t cfg;
  logic q_push, q_full, q_pop, q_empty;
  job_t q_data, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.blur_divisor <= RST_BLUR_DIVISOR;
      cfg.red_fade     <= RST_RED_FADE;
      cfg.green_fade   <= RST_GREEN_FADE;
      cfg.blue_fade    <= RST_BLUE_FADE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        REG_BLUR_DIVISOR: cfg.blur_divisor <= cfg_data[7:0];
        REG_RED_FADE:     cfg.red_fade     <= cfg_data[7:0];
        REG_GREEN_FADE:   cfg.green_fade   <= cfg_data[7:0];
        REG_BLUE_FADE:    cfg.blue_fade    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  bfp_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .push  (push),
    .pixel (pixel),
    .full  (full),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_data)
  );

  bfp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .data (q_data),
    .full (q_full),
    .pop  (q_pop),
    .head (q_head),
    .empty(q_empty)
  );

  bfp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (q_head),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  a_fe_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_end) |-> result.run_last)
    else $error("frame end without run end");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front took a pixel while updating line store");

  a_pop_has_job: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job queue popped while empty");

endmodule
